>>> sv/machine_timer_compare_top_defines.svh
// ----------------------------------------------------------------------------
// Machine timer compare assertion macros
// Shared property forms for the checker of the machine timer block.
// ----------------------------------------------------------------------------
`ifndef MACHINE_TIMER_COMPARE_TOP_DEFINES_SVH
`define MACHINE_TIMER_COMPARE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and masked during reset.
`define MTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("machine timer check failed");

// Next-cycle implication, sampled on i_clk and masked during reset.
`define MTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("machine timer check failed");

// Condition that must hold in the cycle after reset is applied.
`define MTC_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("machine timer reset check failed");

`endif

>>> sv/mtc_pkg.sv
// ----------------------------------------------------------------------------
// Machine timer compare package
// Types and constants shared by the front end, the back end and the queues.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [3:0] ADDR_TIME_LO = 4'h0;
    localparam logic [3:0] ADDR_TIME_HI = 4'h4;
    localparam logic [3:0] ADDR_CMP_LO  = 4'h8;
    localparam logic [3:0] ADDR_CMP_HI  = 4'hc;

    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_TICK,
        OP_RD_LO,
        OP_RD_HI,
        OP_WR_LO,
        OP_WR_HI,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               timer_irq;
        logic               access_error;
    } t_rsp;

endpackage

`default_nettype wire

>>> sv/mtc_fifo.sv
// ----------------------------------------------------------------------------
// Machine timer small queue
// Short first-in first-out buffer used between the pipeline parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_fifo
    import mtc_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_full    = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/mtc_front.sv
// ----------------------------------------------------------------------------
// Machine timer front end
// Accepts items, decodes mode and offset into an operation, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_front
    import mtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [1:0]        i_mode,
    input  wire logic [3:0]        i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output t_cmd                   o_cmd,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_take
);

    t_cmd                w_cmd;
    logic [$bits(t_cmd)-1:0] w_q_data;
    logic                w_q_empty;

    always_comb begin
        w_cmd.data = i_write_data;
        case (i_mode)
            MODE_TICK: begin
                w_cmd.op = OP_TICK;
            end
            MODE_READ: begin
                if (i_address == ADDR_TIME_LO) begin
                    w_cmd.op = OP_RD_LO;
                end else if (i_address == ADDR_TIME_HI) begin
                    w_cmd.op = OP_RD_HI;
                end else begin
                    w_cmd.op = OP_ERR;
                end
            end
            MODE_WRITE: begin
                if (i_address == ADDR_CMP_LO) begin
                    w_cmd.op = OP_WR_LO;
                end else if (i_address == ADDR_CMP_HI) begin
                    w_cmd.op = OP_WR_HI;
                end else begin
                    w_cmd.op = OP_ERR;
                end
            end
            default: begin
                w_cmd.op = OP_ERR;
            end
        endcase
    end

    mtc_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (w_cmd),
        .i_pop   (i_cmd_take),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    assign o_cmd       = t_cmd'(w_q_data);
    assign o_cmd_valid = !w_q_empty;

endmodule

`default_nettype wire

>>> sv/mtc_back.sv
// ----------------------------------------------------------------------------
// Machine timer back end
// Holds the time and compare state, executes queued operations, and queues
// one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_back
    import mtc_pkg::*;
#(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_take,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output t_rsp                   o_rsp
);

    logic [TIME_WIDTH-1:0] r_time;
    logic [TIME_WIDTH-1:0] n_time;
    logic [WIDE_W-1:0]     r_latch;
    logic [WIDE_W-1:0]     n_latch;
    logic [WIDE_W-1:0]     r_cmp;
    logic [WIDE_W-1:0]     n_cmp;
    logic [DATA_W-1:0]     r_cmp_lo;
    logic [DATA_W-1:0]     n_cmp_lo;
    logic                  r_irq;
    logic                  n_irq;
    logic                  r_armed;
    logic                  n_armed;
    t_rsp                  w_rsp;
    logic                  w_rsp_full;
    logic [$bits(t_rsp)-1:0] w_rsp_data;

    // An operation runs only when its result has room to land.
    assign o_cmd_take = i_cmd_valid && !w_rsp_full;

    always_comb begin
        n_time   = r_time;
        n_latch  = r_latch;
        n_cmp    = r_cmp;
        n_cmp_lo = r_cmp_lo;
        n_irq    = r_irq;
        n_armed  = r_armed;
        w_rsp    = '0;
        case (i_cmd.op)
            OP_TICK: begin
                n_time = r_time + 1'b1;
                if (r_armed && (WIDE_W'(n_time) >= r_cmp)) begin
                    n_irq   = 1'b1;
                    n_armed = 1'b0;
                end
            end
            OP_RD_LO: begin
                n_latch         = WIDE_W'(r_time);
                w_rsp.read_data = r_time[DATA_W-1:0];
            end
            OP_RD_HI: begin
                w_rsp.read_data = r_latch[WIDE_W-1:DATA_W];
            end
            OP_WR_LO: begin
                n_cmp_lo = i_cmd.data;
            end
            OP_WR_HI: begin
                n_cmp = {i_cmd.data, r_cmp_lo};
                // A compare value already reached fires at once; otherwise wait for ticks.
                if (n_cmp <= WIDE_W'(r_time)) begin
                    n_irq   = 1'b1;
                    n_armed = 1'b0;
                end else begin
                    n_irq   = 1'b0;
                    n_armed = 1'b1;
                end
            end
            default: begin
                w_rsp.access_error = 1'b1;
            end
        endcase
        w_rsp.timer_irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_latch  <= '0;
            r_cmp    <= '0;
            r_cmp_lo <= '0;
            r_irq    <= 1'b0;
            r_armed  <= 1'b0;
        end else if (o_cmd_take) begin
            r_time   <= n_time;
            r_latch  <= n_latch;
            r_cmp    <= n_cmp;
            r_cmp_lo <= n_cmp_lo;
            r_irq    <= n_irq;
            r_armed  <= n_armed;
        end
    end

    mtc_fifo #(
        .WIDTH ($bits(t_rsp))
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_cmd_take),
        .o_full  (w_rsp_full),
        .i_data  (w_rsp),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (w_rsp_data)
    );

    assign o_rsp = t_rsp'(w_rsp_data);

endmodule

`default_nettype wire

>>> sv/machine_timer_compare_top.sv
// ----------------------------------------------------------------------------
// Machine timer compare top level
// Usage:
//   Input side is a queue: drive mode, address and write data with push;
//   the transaction is taken on a clock edge where push is high and full
//   is low. Mode selects a time tick, a bus read or a bus write.
//   Output side is a queue: while empty is low the oldest result (read
//   data, interrupt pending, access error) is on the ports, and it is
//   taken on an edge where pop is high and empty is low.
//   Every transaction gives exactly one result, in order.
//   A taken transaction is registered in the command queue; once it is at
//   the head and the result queue has room, the execute stage works on it
//   and writes its result into the result queue, where empty falls.
//   Throughput is one transaction per cycle while the result queue has
//   room, set by the execute stage (64-bit increment and compare).
//   When the receiver stalls, the result queue fills, the execute stage
//   stops, then the two-entry command queue fills and full rises.
//   Synchronous reset clears time, latch, compare, interrupt and both
//   queues; full and empty read low and high in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module machine_timer_compare_top
    import mtc_pkg::*;
#(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        i_mode,
    input  wire logic [3:0]        i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   empty,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_timer_irq,
    output logic                   o_access_error
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_take;
    t_rsp w_rsp;

    mtc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_cmd        (w_cmd),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_take   (w_cmd_take)
    );

    mtc_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rsp       (w_rsp)
    );

    assign o_read_data    = w_rsp.read_data;
    assign o_timer_irq    = w_rsp.timer_irq;
    assign o_access_error = w_rsp.access_error;

endmodule

`default_nettype wire

>>> sv/mtc_checker.sv
// ----------------------------------------------------------------------------
// Machine timer port checker
// Watches the top-level ports and checks reset, result and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "machine_timer_compare_top_defines.svh"

module mtc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_read_data,
    input wire logic        o_timer_irq,
    input wire logic        o_access_error
);

    // Both queues come out of reset drained.
    `MTC_ASSERT_RST(a_reset_queues, empty && !full)

    // A rejected access never returns read data.
    `MTC_ASSERT_NOW(a_error_no_data, !empty && o_access_error, o_read_data == 32'd0)

    // A result that is not taken stays on the ports unchanged.
    `MTC_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(o_read_data) && $stable({o_timer_irq, o_access_error}))

endmodule

bind machine_timer_compare_top mtc_checker u_mtc_checker (.*);

`default_nettype wire

>>> verif/machine_timer_compare_checker.sv
// ----------------------------------------------------------------------------
// Machine timer compare checker
// Watches both queue interfaces of the timer, predicts the result of every
// accepted transaction and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module machine_timer_compare_checker
    import mtc_pkg::*;
#(
    parameter int TIME_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [1:0]        i_mode,
    input  logic [3:0]        i_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [DATA_W-1:0] i_read_data,
    input  logic              i_timer_irq,
    input  logic              i_access_error,
    output int                o_outstanding,
    output int                o_fail_count,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [WIDE_W-1:0] TIME_MASK = {WIDE_W{1'b1}} >> (WIDE_W - TIME_WIDTH);

    // Shadow copy of the timer state.
    logic [WIDE_W-1:0] now_time;
    logic [WIDE_W-1:0] time_snapshot;
    logic [WIDE_W-1:0] cmp_value;
    logic [DATA_W-1:0] cmp_low_staged;
    logic              irq_pending;
    logic              armed;

    t_rsp timer_rsp_q[$];
    int   fail_total;
    int   checked_total;

    function automatic t_rsp apply_timer_item(input logic [1:0] mode,
                                              input logic [3:0] addr,
                                              input logic [DATA_W-1:0] data);
        t_rsp rsp;
        rsp = '0;
        case (mode)
            MODE_TICK: begin
                now_time = (now_time + 1'b1) & TIME_MASK;
                if (armed && now_time >= cmp_value) begin
                    irq_pending = 1'b1;
                    armed       = 1'b0;
                end
            end
            MODE_READ: begin
                if (addr == ADDR_TIME_LO) begin
                    time_snapshot = now_time;
                    rsp.read_data = time_snapshot[DATA_W-1:0];
                end else if (addr == ADDR_TIME_HI) begin
                    rsp.read_data = time_snapshot[WIDE_W-1:DATA_W];
                end else begin
                    rsp.access_error = 1'b1;
                end
            end
            MODE_WRITE: begin
                if (addr == ADDR_CMP_LO) begin
                    cmp_low_staged = data;
                end else if (addr == ADDR_CMP_HI) begin
                    cmp_value = {data, cmp_low_staged};
                    // A compare at or below the current time fires at once.
                    if (cmp_value <= now_time) begin
                        irq_pending = 1'b1;
                        armed       = 1'b0;
                    end else begin
                        irq_pending = 1'b0;
                        armed       = 1'b1;
                    end
                end else begin
                    rsp.access_error = 1'b1;
                end
            end
            default: begin
                rsp.access_error = 1'b1;
            end
        endcase
        rsp.timer_irq = irq_pending;
        return rsp;
    endfunction

    initial begin
        o_outstanding = 0;
        o_fail_count  = 0;
        o_checked     = 0;
        fail_total    = 0;
        checked_total = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            now_time       = '0;
            time_snapshot  = '0;
            cmp_value      = '0;
            cmp_low_staged = '0;
            irq_pending    = 1'b0;
            armed          = 1'b0;
            timer_rsp_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (timer_rsp_q.size() == 0) begin
                    $display("%0t: result with nothing expected: read_data %h irq %b error %b",
                             $time, i_read_data, i_timer_irq, i_access_error);
                    fail_total++;
                end else begin
                    want = timer_rsp_q.pop_front();
                    checked_total++;
                    if (i_read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch, expected %h, got %h",
                                 $time, want.read_data, i_read_data);
                        fail_total++;
                    end
                    if (i_timer_irq !== want.timer_irq) begin
                        $display("%0t: timer_irq mismatch, expected %b, got %b",
                                 $time, want.timer_irq, i_timer_irq);
                        fail_total++;
                    end
                    if (i_access_error !== want.access_error) begin
                        $display("%0t: access_error mismatch, expected %b, got %b",
                                 $time, want.access_error, i_access_error);
                        fail_total++;
                    end
                end
            end
            if (i_push && !i_full) begin
                timer_rsp_q.push_back(apply_timer_item(i_mode, i_address, i_write_data));
            end
        end
        o_outstanding <= timer_rsp_q.size();
        o_fail_count  <= fail_total;
        o_checked     <= checked_total;
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Machine timer compare testbench
// Drives ticks, time reads and compare writes into the timer with random
// gaps and result stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import mtc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_WIDTH  = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 850;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [1:0]        i_mode;
    logic [3:0]        i_address;
    logic [DATA_W-1:0] i_write_data;
    logic              empty;
    logic              pop;
    logic [DATA_W-1:0] o_read_data;
    logic              o_timer_irq;
    logic              o_access_error;

    int   outstanding;
    int   fail_count;
    int   checked;
    int   cycle_count;
    int   sent_count;
    int   cmp_programs;
    int   pop_hold;
    logic steady;
    logic [WIDE_W-1:0] elapsed_ticks;

    machine_timer_compare_top #(.TIME_WIDTH(TIME_WIDTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .empty          (empty),
        .pop            (pop),
        .o_read_data    (o_read_data),
        .o_timer_irq    (o_timer_irq),
        .o_access_error (o_access_error)
    );

    machine_timer_compare_checker #(.TIME_WIDTH(TIME_WIDTH)) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_read_data    (o_read_data),
        .i_timer_irq    (o_timer_irq),
        .i_access_error (o_access_error),
        .o_outstanding  (outstanding),
        .o_fail_count   (fail_count),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: mostly random idle cycles, now and then a longer stall
    // that can back up both queues until full rises.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else if (steady) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(99) < 2) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(10, 4);
        end else begin
            pop <= ($urandom_range(99) >= 10);
        end
    end

    task automatic send_timer_item(input logic [1:0] mode, input logic [3:0] addr,
                                   input logic [DATA_W-1:0] data);
        while (!steady && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (full);
        sent_count++;
        if (mode == MODE_TICK) begin
            elapsed_ticks++;
        end
    endtask

    task automatic send_ticks(input int count);
        for (int k = 0; k < count; k++) begin
            send_timer_item(MODE_TICK, 4'($urandom), $urandom);
        end
    endtask

    task automatic program_compare(input logic [DATA_W-1:0] low,
                                   input logic [DATA_W-1:0] high);
        send_timer_item(MODE_WRITE, ADDR_CMP_LO, low);
        send_timer_item(MODE_WRITE, ADDR_CMP_HI, high);
        cmp_programs++;
    endtask

    // Holds the sender until every expected result has been taken.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int start_count;
        int pick;
        logic [DATA_W-1:0] low;

        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_mode        <= MODE_TICK;
        i_address     <= ADDR_TIME_LO;
        i_write_data  <= '0;
        steady        <= 1'b0;
        cycle_count   = 0;
        sent_count    = 0;
        cmp_programs  = 0;
        elapsed_ticks = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Ticks ignore their address and data fields.
        send_timer_item(MODE_TICK, 4'hf, 32'hffff_ffff);
        send_timer_item(MODE_TICK, ADDR_TIME_LO, 32'h0);
        send_timer_item(MODE_READ, ADDR_TIME_LO, 32'h0);
        send_timer_item(MODE_READ, ADDR_TIME_HI, 32'h0);
        // The largest compare value arms the timer but can never fire.
        program_compare(32'hffff_ffff, 32'hffff_ffff);
        send_ticks(1);
        // A compare of zero is already in the past and fires immediately.
        program_compare(32'h0, 32'h0);
        // Rewriting the compare clears the interrupt, then ticks fire it.
        program_compare(elapsed_ticks[DATA_W-1:0] + 3, 32'h0);
        send_ticks(4);
        // Unimplemented accesses: compare reads and time writes.
        send_timer_item(MODE_READ, ADDR_CMP_LO, 32'h0);
        send_timer_item(MODE_READ, ADDR_CMP_HI, 32'h0);
        send_timer_item(MODE_WRITE, ADDR_TIME_LO, 32'h1234_5678);
        send_timer_item(MODE_WRITE, ADDR_TIME_HI, 32'hffff_ffff);
        // Offsets outside the register windows and the unused mode.
        send_timer_item(MODE_READ, 4'h2, 32'h0);
        send_timer_item(MODE_WRITE, 4'hf, 32'hffff_ffff);
        send_timer_item(MODE_RSVD, ADDR_TIME_LO, 32'h0);
        send_timer_item(MODE_RSVD, ADDR_CMP_HI, 32'hffff_ffff);
        // A compare equal to the current time counts as reached.
        program_compare(elapsed_ticks[DATA_W-1:0], 32'h0);
        send_timer_item(MODE_READ, ADDR_TIME_LO, 32'h0);
        send_timer_item(MODE_READ, ADDR_TIME_HI, 32'h0);

        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS) begin
            if (sent_count - start_count >= 400 && sent_count - start_count < 405) begin
                drain_results();
            end
            steady <= (sent_count - start_count >= 500 && sent_count - start_count < 650);
            pick = $urandom_range(99);
            if (pick < 35) begin
                // Program a compare near the current time, then tick toward it.
                if ($urandom_range(3) == 0) begin
                    low = elapsed_ticks[DATA_W-1:0] - $urandom_range(5);
                end else begin
                    low = elapsed_ticks[DATA_W-1:0] + $urandom_range(12);
                end
                program_compare(low, elapsed_ticks[WIDE_W-1:DATA_W]);
                send_ticks($urandom_range(15));
            end else if (pick < 55) begin
                send_timer_item(MODE_READ, ADDR_TIME_LO, $urandom);
                send_ticks($urandom_range(2));
                send_timer_item(MODE_READ, ADDR_TIME_HI, $urandom);
            end else if (pick < 75) begin
                send_ticks($urandom_range(8, 1));
            end else if (pick < 85) begin
                program_compare($urandom, $urandom);
            end else begin
                send_timer_item(2'($urandom), 4'($urandom), $urandom);
            end
        end
        steady <= 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d transactions: %0d ticks, %0d compare programs, %0d results checked.",
                 sent_count, elapsed_ticks, cmp_programs, checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
